[hw/rtl/bfi_pkg.sv]
// types, command codes and status codes for the tape language interpreter
package bfi_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_POP
    } t_state;

    typedef enum logic [2:0] {
        OP_INC   = 3'd0,
        OP_DEC   = 3'd1,
        OP_RIGHT = 3'd2,
        OP_LEFT  = 3'd3,
        OP_OUT   = 3'd4,
        OP_IN    = 3'd5,
        OP_OPEN  = 3'd6,
        OP_CLOSE = 3'd7
    } t_op;

    typedef struct packed {
        logic is_cmd;
        t_op  op;
    } t_decoded;

    localparam logic [2:0] ST_LOADED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_OUTPUT    = 3'd2;
    localparam logic [2:0] ST_NEED_IN   = 3'd3;
    localparam logic [2:0] ST_HALTED    = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;
    localparam logic [2:0] ST_UNDERFLOW = 3'd6;

    localparam int          CNT_W       = 17;
    localparam logic [16:0] SLICE_LIMIT = 17'd65536;

    // source byte to command code
    function automatic t_decoded decode_byte(input logic [7:0] b);
        t_decoded d;
        d.is_cmd = 1'b1;
        d.op     = OP_INC;
        case (b)
            8'h2B: d.op = OP_INC;
            8'h2D: d.op = OP_DEC;
            8'h3E: d.op = OP_RIGHT;
            8'h3C: d.op = OP_LEFT;
            8'h2E: d.op = OP_OUT;
            8'h2C: d.op = OP_IN;
            8'h5B: d.op = OP_OPEN;
            8'h5D: d.op = OP_CLOSE;
            default: d.is_cmd = 1'b0;
        endcase
        return d;
    endfunction

endpackage

[hw/rtl/bfi_ram.sv]
// generic single write, single read ram with registered read
module bfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/brainfuck_interpreter_core.sv]
// top level of the tape language interpreter core
// A load beat (start with i_operation 0) appends one command byte and answers
// on the next cycle. A run beat executes from the current instruction pointer
// until an output, a second input request, the program end, a loop stack
// error or a slice of 65536 instructions, then gives one result. Each
// instruction reads program and tape memory in the fetch step, then executes;
// a ']' that jumps back adds a pop step for the loop stack memory read. The
// result is registered from the final step and shown on o_valid for one
// cycle only; the receiver must take it then. After reset busy stays high
// while the tape memory is cleared.
module brainfuck_interpreter_core #(
    parameter int PROG_DEPTH  = 1024,
    parameter int TAPE_DEPTH  = 1024,
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_operation,
    input  logic [7:0] i_source_byte,
    input  logic [7:0] i_input_value,
    output logic       o_valid,
    output logic [2:0] o_status,
    output logic [7:0] o_out_value,
    output logic       o_input_taken
);
    import bfi_pkg::*;

    localparam int PAW = $clog2(PROG_DEPTH);
    localparam int IPW = PAW + 1;
    localparam int TAW = $clog2(TAPE_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int STW = SAW + 1;

    t_state         r_state, n_state;
    logic [IPW-1:0] r_len, n_len;
    logic [IPW-1:0] r_ip, n_ip;
    logic [TAW-1:0] r_cp, n_cp;
    logic [STW-1:0] r_top, n_top;
    logic           r_skip, n_skip;
    logic [IPW-1:0] r_depth, n_depth;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [TAW-1:0] r_clr, n_clr;
    logic [7:0]     r_in_val, n_in_val;
    logic           r_taken, n_taken;
    logic           r_valid, n_valid;
    logic [2:0]     r_status, n_status;
    logic [7:0]     r_out, n_out;
    logic           r_out_taken, n_out_taken;

    logic           prog_we;
    logic [2:0]     prog_rdata;
    logic           tape_we;
    logic [TAW-1:0] tape_waddr;
    logic [7:0]     tape_wdata, tape_rdata;
    logic           stack_we;
    logic [IPW-1:0] stack_rdata;

    t_decoded       dec;
    t_op            op;
    logic           accept, at_limit, at_end, stack_full;

    assign accept     = start && (r_state == S_IDLE);
    assign dec        = decode_byte(i_source_byte);
    assign op         = t_op'(prog_rdata);
    assign at_limit   = (r_cnt == SLICE_LIMIT);
    assign at_end     = (r_ip >= r_len);
    assign stack_full = (r_top >= STW'(STACK_DEPTH));

    // memories
    bfi_ram #(.WIDTH(3), .DEPTH(PROG_DEPTH)) u_prog (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (r_len[PAW-1:0]),
        .i_wdata (dec.op),
        .i_raddr (r_ip[PAW-1:0]),
        .o_rdata (prog_rdata)
    );

    bfi_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_raddr (r_cp),
        .o_rdata (tape_rdata)
    );

    bfi_ram #(.WIDTH(IPW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (r_top[SAW-1:0]),
        .i_wdata (r_ip),
        .i_raddr (SAW'(r_top - STW'(1))),
        .o_rdata (stack_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == TAW'(TAPE_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept && i_operation) n_state = S_FETCH;
            end
            S_FETCH: begin
                if (at_limit || at_end) n_state = S_IDLE;
                else                    n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_FETCH;
                if (!r_skip) begin
                    case (op)
                        OP_OUT:   n_state = S_IDLE;
                        OP_IN:    if (r_taken) n_state = S_IDLE;
                        OP_OPEN:  if (tape_rdata != 8'd0 && stack_full) n_state = S_IDLE;
                        OP_CLOSE: n_state = (r_top == '0) ? S_IDLE : S_POP;
                        default:  n_state = S_FETCH;
                    endcase
                end
            end
            S_POP:   n_state = S_FETCH;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_len       = r_len;
        n_ip        = r_ip;
        n_cp        = r_cp;
        n_top       = r_top;
        n_skip      = r_skip;
        n_depth     = r_depth;
        n_cnt       = r_cnt;
        n_clr       = r_clr;
        n_in_val    = r_in_val;
        n_taken     = r_taken;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_out       = r_out;
        n_out_taken = r_out_taken;
        prog_we     = 1'b0;
        tape_we     = 1'b0;
        tape_waddr  = r_cp;
        tape_wdata  = tape_rdata;
        stack_we    = 1'b0;
        case (r_state)
            // clearing sweep over the tape
            S_CLEAR: begin
                tape_we    = 1'b1;
                tape_waddr = r_clr;
                tape_wdata = 8'd0;
                n_clr      = r_clr + TAW'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_operation) begin
                        n_in_val = i_input_value;
                        n_taken  = 1'b0;
                        n_cnt    = '0;
                    end else begin
                        n_valid     = 1'b1;
                        n_out       = 8'd0;
                        n_out_taken = 1'b0;
                        n_status    = ST_LOADED;
                        if (dec.is_cmd) begin
                            if (r_len >= IPW'(PROG_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                prog_we = 1'b1;
                                n_len   = r_len + IPW'(1);
                            end
                        end
                    end
                end
            end
            // slice and program end checks before the reads land
            S_FETCH: begin
                if (at_limit || at_end) begin
                    n_valid     = 1'b1;
                    n_status    = at_limit ? ST_LOADED : ST_HALTED;
                    n_out       = 8'd0;
                    n_out_taken = r_taken;
                end
            end
            S_EXEC: begin
                n_cnt       = r_cnt + CNT_W'(1);
                n_out       = 8'd0;
                n_out_taken = r_taken;
                if (r_skip) begin
                    // forward skip with nesting count
                    if (op == OP_CLOSE) begin
                        if (r_depth <= IPW'(1)) begin
                            n_skip  = 1'b0;
                            n_depth = '0;
                        end else begin
                            n_depth = r_depth - IPW'(1);
                        end
                    end else if (op == OP_OPEN) begin
                        n_depth = r_depth + IPW'(1);
                    end
                    n_ip = r_ip + IPW'(1);
                end else begin
                    case (op)
                        OP_INC: begin
                            tape_we    = 1'b1;
                            tape_wdata = tape_rdata + 8'd1;
                            n_ip       = r_ip + IPW'(1);
                        end
                        OP_DEC: begin
                            tape_we    = 1'b1;
                            tape_wdata = tape_rdata - 8'd1;
                            n_ip       = r_ip + IPW'(1);
                        end
                        OP_RIGHT: begin
                            if (r_cp != TAW'(TAPE_DEPTH - 1)) n_cp = r_cp + TAW'(1);
                            n_ip = r_ip + IPW'(1);
                        end
                        OP_LEFT: begin
                            if (r_cp != '0) n_cp = r_cp - TAW'(1);
                            n_ip = r_ip + IPW'(1);
                        end
                        OP_OUT: begin
                            n_ip     = r_ip + IPW'(1);
                            n_valid  = 1'b1;
                            n_status = ST_OUTPUT;
                            n_out    = tape_rdata;
                        end
                        OP_IN: begin
                            if (r_taken) begin
                                n_valid  = 1'b1;
                                n_status = ST_NEED_IN;
                            end else begin
                                tape_we    = 1'b1;
                                tape_wdata = r_in_val;
                                n_taken    = 1'b1;
                                n_ip       = r_ip + IPW'(1);
                            end
                        end
                        OP_OPEN: begin
                            if (tape_rdata == 8'd0) begin
                                n_skip  = 1'b1;
                                n_depth = IPW'(1);
                                n_ip    = r_ip + IPW'(1);
                            end else if (stack_full) begin
                                n_valid  = 1'b1;
                                n_status = ST_OVERFLOW;
                            end else begin
                                stack_we = 1'b1;
                                n_top    = r_top + STW'(1);
                                n_ip     = r_ip + IPW'(1);
                            end
                        end
                        OP_CLOSE: begin
                            if (r_top == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_UNDERFLOW;
                            end else begin
                                n_top = r_top - STW'(1);
                            end
                        end
                        default: n_ip = r_ip;
                    endcase
                end
            end
            // jump back to the saved open bracket
            S_POP:   n_ip = stack_rdata;
            default: n_ip = r_ip;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_len   <= '0;
            r_ip    <= '0;
            r_cp    <= '0;
            r_top   <= '0;
            r_skip  <= 1'b0;
            r_depth <= '0;
            r_cnt   <= '0;
            r_clr   <= '0;
            r_taken <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_ip    <= n_ip;
            r_cp    <= n_cp;
            r_top   <= n_top;
            r_skip  <= n_skip;
            r_depth <= n_depth;
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
            r_taken <= n_taken;
            r_valid <= n_valid;
        end
        r_in_val    <= n_in_val;
        r_status    <= n_status;
        r_out       <= n_out;
        r_out_taken <= n_out_taken;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_value   = r_out;
    assign o_input_taken = r_out_taken;
endmodule

[hw/rtl/bfi_checker.sv]
// port level checks for the interpreter core, bound to the top level
module bfi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_operation,
    input logic       o_valid,
    input logic [2:0] o_status,
    input logic [7:0] o_out_value,
    input logic       o_input_taken
);
    import bfi_pkg::*;

    // a load beat answers on the next cycle and never takes input
    a_load_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_operation |=> o_valid && !o_input_taken)
        else $error("load beat without answer");

    // a result returns the core to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");

    // only output results carry a value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OUTPUT |-> o_out_value == 8'd0)
        else $error("value on non output result");

    // status stays in range
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_UNDERFLOW)
        else $error("status out of range");
endmodule

bind brainfuck_interpreter_core bfi_checker u_bfi_checker (.*);
